// ----- rtl/rcatm_pkg.sv -----
// package for the rc axis timing measurement block
// widths, register indexes, reset values and parameter defaults; no dependencies
`timescale 1ns / 1ps

package rcatm_pkg;

  localparam int TICK_W = 16;
  localparam int AXIS_W = 16;
  localparam int DIS_W  = 8;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam int MIN_TICKS_DEF = 10;
  localparam int MAX_TICKS_DEF = 700;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;

  localparam logic [DIS_W-1:0]  DISCHARGE_RST = 8'd10;
  localparam logic [TICK_W-1:0] TIMEOUT_RST   = 16'd1000;

  localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;
  localparam logic [AXIS_W-1:0] AXIS_MID = 16'h8000;

endpackage

// ----- rtl/rcatm_if.sv -----
// valid/ready channel interfaces for the rc axis timing measurement block
// depends on rcatm_pkg
`timescale 1ns / 1ps

interface rcatm_in_if
  import rcatm_pkg::*;
();
  logic valid;
  logic ready;
  logic opcode;
  logic comparator_level;

  modport source (output valid, output opcode, output comparator_level, input ready);
  modport sink   (input valid, input opcode, input comparator_level, output ready);
endinterface

interface rcatm_out_if
  import rcatm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     drive_low;
  logic                     done_res;
  logic                     timed_out;
  logic [TICK_W-1:0]        elapsed_ticks;
  logic signed [AXIS_W-1:0] axis_value;

  modport source (output valid, output drive_low, output done_res, output timed_out,
                  output elapsed_ticks, output axis_value, input ready);
  modport sink   (input valid, input drive_low, input done_res, input timed_out,
                  input elapsed_ticks, input axis_value, output ready);
endinterface

// ----- rtl/rcatm_scale.sv -----
// three-stage linear scaler: clamp, reciprocal multiply, remainder correction
// depends on rcatm_pkg; the span divide is done at elaboration
`timescale 1ns / 1ps

module rcatm_scale
  import rcatm_pkg::*;
#(
  parameter int MIN_TICKS = MIN_TICKS_DEF,
  parameter int MAX_TICKS = MAX_TICKS_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  logic [TICK_W-1:0] ticks,
  output logic [AXIS_W-1:0] axis_code
);

  localparam bit DEGEN = (MAX_TICKS <= MIN_TICKS);
  localparam int SPAN  = DEGEN ? 1 : (MAX_TICKS - MIN_TICKS);
  localparam longint unsigned RECIP_L = 64'd4294901760 / 64'(SPAN);
  localparam logic [31:0]       RECIP = 32'(RECIP_L);
  localparam logic [TICK_W-1:0] LO    = TICK_W'(MIN_TICKS);
  localparam logic [TICK_W-1:0] HI    = TICK_W'(MIN_TICKS + SPAN);
  localparam logic [TICK_W-1:0] SPAN_V = TICK_W'(SPAN);

  logic [TICK_W-1:0] n_nxt, n_r, n2_r;
  logic [47:0]       prod;
  logic [31:0]       p_r;
  logic [TICK_W-1:0] q0, q;
  logic [31:0]       num, qd, rem;
  logic [AXIS_W-1:0] axis_nxt, axis_r;

  // clamp into [lo, hi] and offset
  always_comb begin
    if (ticks < LO) begin
      n_nxt = '0;
    end else if (ticks > HI) begin
      n_nxt = SPAN_V;
    end else begin
      n_nxt = ticks - LO;
    end
  end

  // n * floor(65535 * 2^16 / span), fits 32 bits since n <= span
  assign prod = {32'd0, n_r} * {16'd0, RECIP};

  // estimate is exact or one low
  always_comb begin
    q0  = p_r[31:16];
    num = {n2_r, 16'd0} - {16'd0, n2_r};
    qd  = {16'd0, q0} * {16'd0, SPAN_V};
    rem = num - qd;
    q   = (rem >= {16'd0, SPAN_V}) ? q0 + 16'd1 : q0;
    if (DEGEN) begin
      axis_nxt = AXIS_MID;
    end else begin
      axis_nxt = q ^ AXIS_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      p_r    <= prod[31:0];
      n2_r   <= n_r;
      axis_r <= axis_nxt;
    end
  end

  assign axis_code = axis_r;

endmodule

// ----- rtl/rc_axis_timing_measure_top.sv -----
// rc axis timing measurement: an accepted word passes res_a, res_b, res_c and res_d to the result word
// throughput one word per cycle; the whole pipeline stalls only when the result is held
// the phase/count update is done at accept, then three scaler stages follow
// reset (synchronous, active low) clears phase, count and valid bits and loads
// discharge 10 and timeout 1000; no clearing pass
// depends on rcatm_pkg, rcatm_if and rcatm_scale
`timescale 1ns / 1ps

module rc_axis_timing_measure_top
  import rcatm_pkg::*;
#(
  parameter int MIN_TICKS = MIN_TICKS_DEF,
  parameter int MAX_TICKS = MAX_TICKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rcatm_in_if.sink             in_ch,
  rcatm_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_DISCHARGE = 2'd1;
  localparam logic [1:0] PH_CHARGE    = 2'd2;

  typedef struct packed {
    logic              drive;
    logic              done;
    logic              tmo;
    logic              zero;
    logic [TICK_W-1:0] elapsed;
  } res_t;

  logic [DIS_W-1:0]  discharge_r;
  logic [TICK_W-1:0] timeout_r;
  logic [1:0]        phase_r, phase_nxt;
  logic [TICK_W-1:0] cnt_r, cnt_nxt, cnt_inc, cnt_sat;
  res_t              res_nxt, res_a_r, res_b_r, res_c_r, res_d_r;
  logic              a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  logic              adv, accept;
  logic [AXIS_W-1:0] axis_code;

  assign adv    = !d_vld_r || out_ch.ready;
  assign accept = in_ch.valid && adv;
  assign in_ch.ready = adv;

  assign cnt_inc = cnt_r + 16'd1;
  assign cnt_sat = (cnt_r == TICK_MAX) ? cnt_r : cnt_inc;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    res_nxt   = '{drive: 1'b0, done: 1'b0, tmo: 1'b0, zero: 1'b1, elapsed: '0};
    if (in_ch.opcode) begin
      cnt_nxt = '0;
      if (discharge_r == '0) begin
        phase_nxt = PH_CHARGE;
      end else begin
        phase_nxt     = PH_DISCHARGE;
        res_nxt.drive = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_DISCHARGE: begin
          if (cnt_inc >= {8'd0, discharge_r}) begin
            phase_nxt = PH_CHARGE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt       = cnt_inc;
            res_nxt.drive = 1'b1;
          end
        end
        PH_CHARGE: begin
          cnt_nxt = cnt_sat;
          // comparator wins over timeout on the same tick
          if (in_ch.comparator_level) begin
            res_nxt.done    = 1'b1;
            res_nxt.elapsed = cnt_sat;
            res_nxt.zero    = (cnt_sat >= timeout_r);
            phase_nxt       = PH_IDLE;
            cnt_nxt         = '0;
          end else if (cnt_sat > timeout_r || cnt_sat == TICK_MAX) begin
            res_nxt.done    = 1'b1;
            res_nxt.tmo     = 1'b1;
            res_nxt.elapsed = timeout_r;
            phase_nxt       = PH_IDLE;
            cnt_nxt         = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discharge_r <= DISCHARGE_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISCHARGE: discharge_r <= cfg_data[DIS_W-1:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      if (accept) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
      a_vld_r <= accept;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_a_r <= res_nxt;
      res_b_r <= res_a_r;
      res_c_r <= res_b_r;
      res_d_r <= res_c_r;
    end
  end

  rcatm_scale #(
    .MIN_TICKS(MIN_TICKS),
    .MAX_TICKS(MAX_TICKS)
  ) u_scale (
    .clk      (clk),
    .en       (adv),
    .ticks    (res_a_r.elapsed),
    .axis_code(axis_code)
  );

  assign out_ch.valid         = d_vld_r;
  assign out_ch.drive_low     = res_d_r.drive;
  assign out_ch.done_res      = res_d_r.done;
  assign out_ch.timed_out     = res_d_r.tmo;
  assign out_ch.elapsed_ticks = res_d_r.elapsed;
  assign out_ch.axis_value    = res_d_r.zero ? '0 : $signed(axis_code);

endmodule

// ----- rtl/rcatm_checker.sv -----
// port-level checks for the rc axis timing measurement block, bound to the top level
// depends on rcatm_pkg and rc_axis_timing_measure_top
`timescale 1ns / 1ps

module rcatm_checker
  import rcatm_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     drive_low,
  input logic                     done_res,
  input logic                     timed_out,
  input logic [TICK_W-1:0]        elapsed_ticks,
  input logic signed [AXIS_W-1:0] axis_value
);

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(elapsed_ticks) && $stable(axis_value)
      && $stable(done_res) && $stable(timed_out) && $stable(drive_low))
    else $error("result word changed while stalled");

  // an empty output stage never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_timeout_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && timed_out |-> done_res && axis_value == '0 && !drive_low)
    else $error("timeout word malformed");

  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !done_res |-> !timed_out && elapsed_ticks == '0 && axis_value == '0)
    else $error("non-final word carries measurement data");

  a_drive_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && drive_low |-> !done_res)
    else $error("discharge drive on a completing word");

endmodule

bind rc_axis_timing_measure_top rcatm_checker u_rcatm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .drive_low    (out_ch.drive_low),
  .done_res     (out_ch.done_res),
  .timed_out    (out_ch.timed_out),
  .elapsed_ticks(out_ch.elapsed_ticks),
  .axis_value   (out_ch.axis_value)
);
